// ----- rtl/jhss_pkg.sv -----
// Shared types and constants for the JPEG header size scanner.
package jhss_pkg;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_EOI    = 8'hD9;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;
  localparam logic [7:0] MARKER_APP0   = 8'hE0;
  localparam logic [7:0] MARKER_DQT    = 8'hDB;
  localparam logic [7:0] MARKER_DHT    = 8'hC4;
  localparam logic [7:0] MARKER_SOS    = 8'hDA;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NO_SOI = 2'd1;
  localparam logic [1:0] ST_EOI    = 2'd2;
  localparam logic [1:0] ST_ENDED  = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } jhss_res_t;

endpackage

// ----- rtl/jhss_parser.sv -----
// Marker parser: the per-byte state update and result decision.
module jhss_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        byte_in,
  input  logic              is_last,
  output jhss_pkg::jhss_res_t res
);
  import jhss_pkg::*;

  localparam logic [3:0] MODE_SOI0       = 4'd0;
  localparam logic [3:0] MODE_SOI1       = 4'd1;
  localparam logic [3:0] MODE_SCAN       = 4'd2;
  localparam logic [3:0] MODE_LEN_HI     = 4'd3;
  localparam logic [3:0] MODE_LEN_LO     = 4'd4;
  localparam logic [3:0] MODE_SKIP_SEG   = 4'd5;
  localparam logic [3:0] MODE_FRAME_SKIP = 4'd6;
  localparam logic [3:0] MODE_H_HI       = 4'd7;
  localparam logic [3:0] MODE_H_LO       = 4'd8;
  localparam logic [3:0] MODE_W_HI       = 4'd9;
  localparam logic [3:0] MODE_W_LO       = 4'd10;
  localparam logic [3:0] MODE_DONE       = 4'd11;

  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] width_r, width_nxt;

  logic        emit;
  logic [1:0]  emit_status;
  logic        idle_arm;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic        skip_marker;

  always_comb begin
    seg_len     = {len_hi_r, byte_in};
    skip_dec    = skip_r - 16'd1;
    skip_marker = (byte_in >= MARKER_APP0) || (byte_in == MARKER_DQT) ||
                  (byte_in == MARKER_DHT) || (byte_in == MARKER_SOS);

    mode_nxt      = mode_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    skip_nxt      = skip_r;
    len_hi_nxt    = len_hi_r;
    height_nxt    = height_r;
    width_nxt     = width_r;
    emit          = 1'b0;
    emit_status   = ST_ENDED;
    idle_arm      = 1'b0;

    case (mode_r)
      MODE_SOI0: begin
        if (byte_in != MARKER_PREFIX || is_last) begin
          emit        = 1'b1;
          emit_status = ST_NO_SOI;
        end else begin
          mode_nxt = MODE_SOI1;
        end
      end
      MODE_SOI1: begin
        if (byte_in != MARKER_SOI) begin
          emit        = 1'b1;
          emit_status = ST_NO_SOI;
        end else begin
          mode_nxt      = MODE_SCAN;
          have_prev_nxt = 1'b0;
        end
      end
      MODE_SCAN: begin
        if (!have_prev_r) begin
          prev_nxt      = byte_in;
          have_prev_nxt = 1'b1;
        end else if (prev_r == MARKER_PREFIX && byte_in == MARKER_EOI) begin
          emit        = 1'b1;
          emit_status = ST_EOI;
        end else if (prev_r == MARKER_PREFIX && byte_in == MARKER_SOF0) begin
          skip_nxt = 16'd3;
          mode_nxt = MODE_FRAME_SKIP;
        end else if (prev_r == MARKER_PREFIX && skip_marker) begin
          mode_nxt = MODE_LEN_HI;
        end else begin
          prev_nxt = byte_in;
        end
      end
      MODE_LEN_HI: begin
        len_hi_nxt = byte_in;
        mode_nxt   = MODE_LEN_LO;
      end
      MODE_LEN_LO: begin
        // Lengths below two are repaired to two: nothing left to skip.
        skip_nxt = (seg_len < 16'd2) ? 16'd0 : (seg_len - 16'd2);
        if (seg_len <= 16'd2) begin
          mode_nxt      = MODE_SCAN;
          have_prev_nxt = 1'b0;
        end else begin
          mode_nxt = MODE_SKIP_SEG;
        end
      end
      MODE_SKIP_SEG: begin
        skip_nxt = skip_dec;
        if (skip_dec == 16'd0) begin
          mode_nxt      = MODE_SCAN;
          have_prev_nxt = 1'b0;
        end
      end
      MODE_FRAME_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 16'd0) begin
          mode_nxt = MODE_H_HI;
        end
      end
      MODE_H_HI: begin
        height_nxt = {byte_in, 8'h00};
        mode_nxt   = MODE_H_LO;
      end
      MODE_H_LO: begin
        height_nxt = {height_r[15:8], byte_in};
        mode_nxt   = MODE_W_HI;
      end
      MODE_W_HI: begin
        width_nxt = {byte_in, 8'h00};
        mode_nxt  = MODE_W_LO;
      end
      MODE_W_LO: begin
        width_nxt   = {width_r[15:8], byte_in};
        emit        = 1'b1;
        emit_status = ST_FOUND;
      end
      default: begin
        // Result already given: swallow bytes until the file ends.
        idle_arm = 1'b1;
      end
    endcase

    if (emit) begin
      mode_nxt = MODE_DONE;
    end

    // Every path re-arms on the final byte of a file.
    if (is_last) begin
      mode_nxt      = MODE_SOI0;
      prev_nxt      = 8'h00;
      have_prev_nxt = 1'b0;
      skip_nxt      = 16'd0;
      len_hi_nxt    = 8'h00;
      height_nxt    = 16'd0;
      width_nxt     = 16'd0;
    end

    res.valid  = step_en && (emit || (is_last && !idle_arm));
    res.status = emit ? emit_status : ST_ENDED;
    res.height = (emit && emit_status == ST_FOUND) ? height_r : 16'd0;
    res.width  = (emit && emit_status == ST_FOUND) ? {width_r[15:8], byte_in} : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SOI0;
      prev_r      <= 8'h00;
      have_prev_r <= 1'b0;
      skip_r      <= 16'd0;
      len_hi_r    <= 8'h00;
      height_r    <= 16'd0;
      width_r     <= 16'd0;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      skip_r      <= skip_nxt;
      len_hi_r    <= len_hi_nxt;
      height_r    <= height_nxt;
      width_r     <= width_nxt;
    end
  end

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && is_last |=> mode_r == MODE_SOI0 && !have_prev_r)
    else $error("parser did not re-arm after the final byte");

  a_found_from_width: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.status == ST_FOUND |-> mode_r == MODE_W_LO)
    else $error("size reported outside the width byte");

  a_result_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && !is_last |=> mode_r == MODE_DONE)
    else $error("parser kept searching after a result");

endmodule

// ----- rtl/jhss_out_queue.sv -----
// Two-entry result queue that decouples the parser from the result channel.
module jhss_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jhss_pkg::jhss_res_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [15:0]         out_image_height,
  output logic [15:0]         out_image_width
);
  import jhss_pkg::*;

  jhss_res_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full             = (cnt_r == 2'd2);
  assign out_valid        = (cnt_r != 2'd0);
  assign pop              = out_valid && !out_stall;
  assign out_status       = mem_r[rd_ptr_r].status;
  assign out_image_height = mem_r[rd_ptr_r].height;
  assign out_image_width  = mem_r[rd_ptr_r].width;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("result queue count did not drop on a pop");

endmodule

// ----- rtl/jpeg_header_size_scanner_core.sv -----
// Top level of the JPEG header size scanner: input register, parser and result queue.
//
// The block reads a JPEG file one byte per item, with in_is_last marking the
// final byte, and reports the frame size found in the first baseline frame
// header (FF C0). It checks for the start marker FF D8, then walks the markers:
// application, quantization, Huffman and scan segments (FF E0..FF FF, FF DB,
// FF C4, FF DA) are skipped by their big-endian length, with a length below two
// treated as two. Exactly one result item comes out per file: status 0 with the
// height and width, 1 when the start marker is missing, 2 when FF D9 comes
// first, or 3 when the file ends before any of these. Bytes after a result are
// dropped until the final byte, after which the block is ready for a new file.
// Each byte is captured in an input register; when it moves on from there the
// parser state is updated and any result is written into a two-entry result
// queue, so a sustained rate of one byte per clock holds while that queue is not
// full. A result is presented on the out_ ports from the queue's registers.
// in_stall rises only while the result queue is full and a byte is waiting.
module jpeg_header_size_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_image_height,
  output logic [15:0] out_image_width
);
  import jhss_pkg::*;

  logic      in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic      last_r;
  logic      q_full;
  logic      advance;
  logic      in_take;
  jhss_res_t res;

  // The held byte moves into the parser whenever the queue has room for a
  // possible result.
  assign advance  = in_vld_r && !q_full;
  assign in_stall = in_vld_r && q_full;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte_in;
      last_r <= in_is_last;
    end
  end

  jhss_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .byte_in (byte_r),
    .is_last (last_r),
    .res     (res)
  );

  jhss_out_queue u_out_queue (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (res.valid),
    .push_data        (res),
    .full             (q_full),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_image_height (out_image_height),
    .out_image_width  (out_image_width)
  );

endmodule
